// ----- rtl/brsf_pkg.sv -----
// ----------------------------------------------------------------------------
// brsf_pkg
// Shared types, widths and helper functions for the bitmap range set and
// find-first core.
// ----------------------------------------------------------------------------
`default_nettype none

package brsf_pkg;

   // field widths
   localparam int IDX_W     = 11;
   localparam int FIDX_W    = 10;
   localparam int WORD_W    = 64;
   localparam int BIT_W     = 6;
   localparam int SPAN_W    = IDX_W + 1;
   localparam int WSEL_W    = SPAN_W - BIT_W;

   // default store size
   localparam int NBITS_DEF  = 1024;
   localparam int NWORDS_DEF = NBITS_DEF / WORD_W;

   localparam logic [WORD_W-1:0] ONES = '1;

   // operation codes
   localparam logic OP_CHANGE = 1'b0;
   localparam logic OP_FIND   = 1'b1;

   typedef struct packed {
      logic             operation;
      logic [IDX_W-1:0] start_bit;
      logic [IDX_W-1:0] bit_count;
      logic [IDX_W-1:0] search_end;
      logic             target_value;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [FIDX_W-1:0] found_index;
      logic              range_error;
   } rsp_type;

   // mask of bits lo through hi_m1 inclusive
   function automatic logic [WORD_W-1:0] span_mask(input logic [BIT_W-1:0] lo,
                                                    input logic [BIT_W-1:0] hi_m1);
      logic [BIT_W-1:0] top_gap;
      top_gap   = BIT_W'(WORD_W - 1) - hi_m1;
      span_mask = (ONES << lo) & (ONES >> top_gap);
   endfunction

   // index of the lowest set bit, binary search over halves
   function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] low_mask;
      logic [BIT_W-1:0]  idx;
      x   = v;
      idx = '0;
      for (int k = BIT_W - 1; k >= 0; k--) begin
         low_mask = (WORD_W'(1) << (1 << k)) - WORD_W'(1);
         if ((x & low_mask) == '0) begin
            idx[k] = 1'b1;
            x      = x >> (1 << k);
         end
      end
      first_set = idx;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/bitmap_range_set_and_find_first_core.sv -----
// ----------------------------------------------------------------------------
// bitmap_range_set_and_find_first_core
// Bitmap of NBITS bits held as 64-bit words in a RAM. A change request sets
// or clears a run of bits; a find request returns the lowest bit in a range
// that holds a given value. One result word per request.
//
// Channels: req_* carries request words, rsp_* carries result words; a word
// moves on a clock edge with valid high and stall low.
// Sequence: the words of a request's span are read in order and each is
// modified or searched as its read data returns; the result is registered
// after the last word. A find stops at the first matching word. Rejected
// requests and empty searches are registered at the accepting edge and,
// while the output is not stalled, can follow one per cycle.
// Throughput: one request at a time; the shared read-modify-write path
// handles one 64-bit word per cycle and sets the rate.
// Reset: the store is swept to zero, one word per cycle, across all NBITS/64
// words; req_stall stays high during the sweep.
// Stall: a finished result waits in the output register; the next request
// may be accepted and worked on meanwhile, and its result then waits in a
// holding register until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_range_set_and_find_first_core #(
   parameter int NBITS = brsf_pkg::NBITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire brsf_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output brsf_pkg::rsp_type      rsp_word
);

   import brsf_pkg::*;

   localparam int NWORDS = NBITS / WORD_W;
   localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

   // sequencer states
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;
   localparam logic [1:0] ST_HOLD  = 2'd3;

   logic [1:0]        state_ff,   state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic              op_ff,      op_in;
   logic              val_ff,     val_in;
   logic [WSEL_W-1:0] first_w_ff, first_w_in;
   logic [WSEL_W-1:0] last_w_ff,  last_w_in;
   logic [BIT_W-1:0]  lo_ff,      lo_in;
   logic [BIT_W-1:0]  hi_ff,      hi_in;
   logic [WSEL_W-1:0] rd_w_ff,    rd_w_in;
   logic              issue_ff,   issue_in;
   logic              pend_ff,    pend_in;
   logic [WSEL_W-1:0] pend_w_ff,  pend_w_in;
   rsp_type           hold_ff,    hold_in;
   rsp_type           rsp_ff,     rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // ram ports
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [WORD_W-1:0] rd_data;

   // request decode
   logic [SPAN_W-1:0] start_ext;
   logic [SPAN_W-1:0] end_ext;
   logic [SPAN_W-1:0] chg_sum;
   logic [SPAN_W-1:0] last_ix;
   logic              req_err;
   logic              req_empty;
   logic              accept;

   // word processing
   logic [AW+WSEL_W-1:0] rd_wide;
   logic [AW+WSEL_W-1:0] pend_wide;
   logic [BIT_W-1:0]     cur_lo;
   logic [BIT_W-1:0]     cur_hi;
   logic [WORD_W-1:0]    cur_mask;
   logic [WORD_W-1:0]    cand;
   logic                 pend_last;

   // finish path
   logic    fin;
   rsp_type fin_res;
   logic    slot_free;

   brsf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NWORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // range checks and span bounds of the incoming word
   always_comb begin
      start_ext = {1'b0, req_word.start_bit};
      end_ext   = {1'b0, req_word.search_end};
      chg_sum   = start_ext + {1'b0, req_word.bit_count};
      if (req_word.operation == OP_FIND) begin
         req_err   = (req_word.start_bit > req_word.search_end) ||
                     (32'(req_word.search_end) > 32'(NBITS));
         req_empty = (req_word.start_bit == req_word.search_end);
         last_ix   = end_ext - SPAN_W'(1);
      end else begin
         req_err   = (req_word.bit_count == '0) || (32'(chg_sum) > 32'(NBITS));
         req_empty = 1'b0;
         last_ix   = chg_sum - SPAN_W'(1);
      end
   end

   // word mask for the word coming back from the store
   assign rd_wide   = {{AW{1'b0}}, rd_w_ff};
   assign pend_wide = {{AW{1'b0}}, pend_w_ff};
   assign pend_last = (pend_w_ff == last_w_ff);
   assign cur_lo    = (pend_w_ff == first_w_ff) ? lo_ff : '0;
   assign cur_hi    = pend_last ? hi_ff : BIT_W'(WORD_W - 1);
   assign cur_mask  = span_mask(cur_lo, cur_hi);
   assign cand      = (val_ff ? rd_data : ~rd_data) & cur_mask;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      op_in        = op_ff;
      val_in       = val_ff;
      first_w_in   = first_w_ff;
      last_w_in    = last_w_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rd_w_in      = rd_w_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pend_w_in    = pend_w_ff;
      hold_in      = hold_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_wide[AW-1:0];
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = rd_wide[AW-1:0];
      fin          = 1'b0;
      fin_res      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(NWORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_err || req_empty) begin
                  fin                 = 1'b1;
                  fin_res.range_error = req_err;
               end else begin
                  op_in      = req_word.operation;
                  val_in     = req_word.target_value;
                  first_w_in = start_ext[SPAN_W-1:BIT_W];
                  last_w_in  = last_ix[SPAN_W-1:BIT_W];
                  lo_in      = start_ext[BIT_W-1:0];
                  hi_in      = last_ix[BIT_W-1:0];
                  rd_w_in    = start_ext[SPAN_W-1:BIT_W];
                  issue_in   = 1'b1;
                  state_in   = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            // read side: one word per cycle through the span
            if (issue_ff) begin
               rd_en     = 1'b1;
               rd_w_in   = rd_w_ff + WSEL_W'(1);
               pend_in   = 1'b1;
               pend_w_in = rd_w_ff;
               if (rd_w_ff == last_w_ff) begin
                  issue_in = 1'b0;
               end
            end
            // modify side: word read in the previous cycle
            if (pend_ff) begin
               if (op_ff == OP_CHANGE) begin
                  wr_en   = 1'b1;
                  wr_data = val_ff ? (rd_data | cur_mask) : (rd_data & ~cur_mask);
                  fin     = pend_last;
               end else if (cand != '0) begin
                  fin                 = 1'b1;
                  fin_res.found       = 1'b1;
                  fin_res.found_index = {pend_w_ff[FIDX_W-BIT_W-1:0], first_set(cand)};
               end else begin
                  fin = pend_last;
               end
            end
            if (fin) begin
               issue_in = 1'b0;
               pend_in  = 1'b0;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // finished result goes to the output register or waits
      if (fin) begin
         if (slot_free) begin
            state_in = ST_IDLE;
         end else begin
            hold_in  = fin_res;
            state_in = ST_HOLD;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (fin && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = fin_res;
      end else if ((state_ff == ST_HOLD) && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = hold_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      val_ff     <= val_in;
      first_w_ff <= first_w_in;
      last_w_ff  <= last_w_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      rd_w_ff    <= rd_w_in;
      pend_w_ff  <= pend_w_in;
      hold_ff    <= hold_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/brsf_ram.sv -----
// ----------------------------------------------------------------------------
// brsf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brsf_ram #(
   parameter int WIDTH = brsf_pkg::WORD_W,
   parameter int DEPTH = brsf_pkg::NWORDS_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
